// ===== rtl/npt2d_pkg.sv =====
// npt2d_pkg: shared constants, status codes and controller/datapath structs
// for the nearest point table core
// depends on nothing
package npt2d_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 10;
  localparam int IN_W       = 12;
  localparam int DIST_W     = 25;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = ((COORD_BITS + 1 > IN_W) ? COORD_BITS + 1 : IN_W) + 1;
  localparam int MAG_W      = DIFF_W - 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 1;

  // configuration register indexes
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_RANGE = 3'd1,
    ST_FULL  = 3'd2,
    ST_FOUND = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef struct packed {
    logic    load;
    logic    write;
    logic    scan_init;
    logic    issue;
    logic    res;
    status_e code;
  } npt2d_cmd_t;

  typedef struct packed {
    action_e act;
    logic    range_ok;
    logic    full;
    logic    empty;
    logic    last;
    logic    pipe_busy;
  } npt2d_sts_t;

endpackage

// ===== rtl/npt2d_ctrl.sv =====
// npt2d_ctrl: controller state machine, sequences adds and query scans
// depends on npt2d_pkg
module npt2d_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  npt2d_pkg::npt2d_sts_t sts_i,
  output npt2d_pkg::npt2d_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.code = npt2d_pkg::ST_ADDED;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.act == npt2d_pkg::ACT_ADD) begin
          cmd_o.res = 1'b1;
          state_d   = S_IDLE;
          priority if (!sts_i.range_ok) begin
            cmd_o.code = npt2d_pkg::ST_RANGE;
          end else if (sts_i.full) begin
            cmd_o.code = npt2d_pkg::ST_FULL;
          end else begin
            cmd_o.code  = npt2d_pkg::ST_ADDED;
            cmd_o.write = 1'b1;
          end
        end else if (sts_i.empty) begin
          cmd_o.res  = 1'b1;
          cmd_o.code = npt2d_pkg::ST_EMPTY;
          state_d    = S_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.res  = 1'b1;
          cmd_o.code = npt2d_pkg::ST_FOUND;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_EVAL)
    else $error("load not followed by evaluation");

  a_scan_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_init |-> !sts_i.empty)
    else $error("scan started on empty table");

  a_found_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.res && cmd_o.code == npt2d_pkg::ST_FOUND) |-> $past(state_q == S_DRAIN))
    else $error("found result outside drain");

endmodule

// ===== rtl/npt2d_dp.sv =====
// npt2d_dp: datapath with point table memory, limit registers, distance
// pipeline, running minimum and result registers
// depends on npt2d_pkg
module npt2d_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [npt2d_pkg::COORD_BITS-1:0]   cfg_wdata_i,
  input  logic                               action_i,
  input  logic signed [npt2d_pkg::IN_W-1:0]  x_coord_i,
  input  logic signed [npt2d_pkg::IN_W-1:0]  y_coord_i,
  input  npt2d_pkg::npt2d_cmd_t              cmd_i,
  output npt2d_pkg::npt2d_sts_t              sts_o,
  output logic                               done_o,
  output logic [2:0]                         status_o,
  output logic [npt2d_pkg::COORD_BITS-1:0]   nearest_x_o,
  output logic [npt2d_pkg::COORD_BITS-1:0]   nearest_y_o,
  output logic [npt2d_pkg::DIST_W-1:0]       distance_squared_o
);

  localparam int CB = npt2d_pkg::COORD_BITS;
  localparam int IW = npt2d_pkg::IN_W;

  // limit registers
  logic [CB-1:0] max_x_q, max_y_q;

  // latched item
  npt2d_pkg::action_e      act_q;
  logic signed [IW-1:0]    x_q, y_q;

  // table
  logic [2*CB-1:0]                 mem [npt2d_pkg::MAX_POINTS];
  logic [npt2d_pkg::CNT_W-1:0]     cnt_q;
  logic [npt2d_pkg::ADDR_W-1:0]    rd_addr_q;

  // pipeline
  logic                            va_q, vb_q, first_a_q, first_b_q, first_q;
  logic [2*CB-1:0]                 rd_data_q;
  logic [CB-1:0]                   px_b_q, py_b_q;
  logic [npt2d_pkg::SQ_W-1:0]      sqx_q, sqy_q;
  logic [npt2d_pkg::SUM_W-1:0]     sum;
  logic [npt2d_pkg::SUM_W-1:0]     best_d_q;
  logic [CB-1:0]                   best_x_q, best_y_q;

  // results
  logic                            done_q;
  npt2d_pkg::status_e              status_q;
  logic [CB-1:0]                   nx_q, ny_q;
  logic [npt2d_pkg::DIST_W-1:0]    dist_q;

  logic [CB-1:0]                   px_a, py_a;
  logic signed [npt2d_pkg::DIFF_W-1:0] dx, dy;
  logic [npt2d_pkg::MAG_W-1:0]     mx, my;
  logic                            x_ok, y_ok;

  // range check on latched coordinates
  always_comb begin
    x_ok = !x_q[IW-1]
        && ({1'b0, x_q[IW-2:0]} <= (IW)'(max_x_q))
        && ((x_q[IW-2:0] >> CB) == '0);
    y_ok = !y_q[IW-1]
        && ({1'b0, y_q[IW-2:0]} <= (IW)'(max_y_q))
        && ((y_q[IW-2:0] >> CB) == '0);
  end

  always_comb begin
    sts_o.act       = act_q;
    sts_o.range_ok  = x_ok && y_ok;
    sts_o.full      = (cnt_q == (npt2d_pkg::CNT_W)'(npt2d_pkg::MAX_POINTS));
    sts_o.empty     = (cnt_q == '0);
    sts_o.last      = ((npt2d_pkg::CNT_W)'(rd_addr_q) == cnt_q - 1'b1);
    sts_o.pipe_busy = va_q || vb_q;
  end

  // difference and magnitude of the stage a sample, sum of the stage b squares
  always_comb begin
    px_a = rd_data_q[CB-1:0];
    py_a = rd_data_q[2*CB-1:CB];
    dx   = $signed((npt2d_pkg::DIFF_W)'(px_a)) - (npt2d_pkg::DIFF_W)'(x_q);
    dy   = $signed((npt2d_pkg::DIFF_W)'(py_a)) - (npt2d_pkg::DIFF_W)'(y_q);
    mx   = dx[npt2d_pkg::DIFF_W-1] ? (npt2d_pkg::MAG_W)'(-dx) : (npt2d_pkg::MAG_W)'(dx);
    my   = dy[npt2d_pkg::DIFF_W-1] ? (npt2d_pkg::MAG_W)'(-dy) : (npt2d_pkg::MAG_W)'(dy);
    sum  = (npt2d_pkg::SUM_W)'(sqx_q) + (npt2d_pkg::SUM_W)'(sqy_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q   <= '1;
      max_y_q   <= '1;
      cnt_q     <= '0;
      rd_addr_q <= '0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      first_q   <= 1'b0;
      first_a_q <= 1'b0;
      first_b_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == npt2d_pkg::REG_MAX_Y) begin
          max_y_q <= cfg_wdata_i;
        end else begin
          max_x_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.write) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        rd_addr_q <= '0;
        first_q   <= 1'b1;
      end else if (cmd_i.issue) begin
        rd_addr_q <= rd_addr_q + 1'b1;
        first_q   <= 1'b0;
      end
      va_q      <= cmd_i.issue;
      first_a_q <= first_q;
      vb_q      <= va_q;
      first_b_q <= first_a_q;
      done_q    <= cmd_i.res;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[cnt_q[npt2d_pkg::ADDR_W-1:0]] <= {y_q[CB-1:0], x_q[CB-1:0]};
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= npt2d_pkg::action_e'(action_i);
      x_q   <= x_coord_i;
      y_q   <= y_coord_i;
    end
    sqx_q  <= mx * mx;
    sqy_q  <= my * my;
    px_b_q <= px_a;
    py_b_q <= py_a;
    if (vb_q && (first_b_q || sum < best_d_q)) begin
      best_d_q <= sum;
      best_x_q <= px_b_q;
      best_y_q <= py_b_q;
    end
    if (cmd_i.res) begin
      status_q <= cmd_i.code;
      if (cmd_i.code == npt2d_pkg::ST_FOUND) begin
        nx_q   <= best_x_q;
        ny_q   <= best_y_q;
        dist_q <= best_d_q[npt2d_pkg::DIST_W-1:0];
      end else begin
        nx_q   <= '0;
        ny_q   <= '0;
        dist_q <= '0;
      end
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign nearest_x_o        = nx_q;
  assign nearest_y_o        = ny_q;
  assign distance_squared_o = dist_q;

  a_issue_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (npt2d_pkg::CNT_W)'(rd_addr_q) < cnt_q)
    else $error("read beyond stored points");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> !sts_o.full)
    else $error("write into full table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (npt2d_pkg::CNT_W)'(npt2d_pkg::MAX_POINTS))
    else $error("point count overflow");

  a_found_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res && cmd_i.code == npt2d_pkg::ST_FOUND) |-> !(va_q || vb_q))
    else $error("result taken while scan pipeline busy");

endmodule

// ===== rtl/nearest_point_table_2d_core.sv =====
// nearest_point_table_2d_core: an add goes from accepted start through evaluation to done_o
// a query scans the N stored points, one table read per cycle
// through a three stage read, square, compare pipeline; an empty query ends at evaluation
// one item in flight; busy is high from the cycle after start until done is set up
// next start is taken in the done_o cycle, so one item per latency; done_o never stalls
// async active-low reset empties the table and sets both limits to 1023
module nearest_point_table_2d_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic signed [npt2d_pkg::IN_W-1:0]   x_coord_i,
  input  logic signed [npt2d_pkg::IN_W-1:0]   y_coord_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [npt2d_pkg::COORD_BITS-1:0]    cfg_wdata_i,
  output logic                                done_o,
  output logic [2:0]                          status_o,
  output logic [npt2d_pkg::COORD_BITS-1:0]    nearest_x_o,
  output logic [npt2d_pkg::COORD_BITS-1:0]    nearest_y_o,
  output logic [npt2d_pkg::DIST_W-1:0]        distance_squared_o
);

  npt2d_pkg::npt2d_cmd_t cmd;
  npt2d_pkg::npt2d_sts_t sts;

  npt2d_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  npt2d_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .action_i           (action_i),
    .x_coord_i          (x_coord_i),
    .y_coord_i          (y_coord_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .done_o             (done_o),
    .status_o           (status_o),
    .nearest_x_o        (nearest_x_o),
    .nearest_y_o        (nearest_y_o),
    .distance_squared_o (distance_squared_o)
  );

endmodule

// ===== tb/tb_nearest_point_table_2d_core.sv =====
// testbench for nearest_point_table_2d_core: directed and random add and query items
// checked against a behavioural model of the point table, limits written between phases
// depends on npt2d_pkg and nearest_point_table_2d_core
`timescale 1ns / 1ps

module tb_nearest_point_table_2d_core;

  localparam int   COORD_MAX      = (1 << npt2d_pkg::COORD_BITS) - 1;
  localparam int   IN_MAX         = (1 << (npt2d_pkg::IN_W - 1)) - 1;
  localparam int   IN_MIN         = -(1 << (npt2d_pkg::IN_W - 1));
  localparam int   SETTLE_CYCLES  = 8;
  localparam int   WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    npt2d_pkg::status_e                 status;
    logic [npt2d_pkg::COORD_BITS-1:0]   nx;
    logic [npt2d_pkg::COORD_BITS-1:0]   ny;
    logic [npt2d_pkg::DIST_W-1:0]       dist_sq;
  } nearest_result_t;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni;
  logic                                   start;
  logic                                   busy;
  logic                                   action_i;
  logic signed [npt2d_pkg::IN_W-1:0]      x_coord_i;
  logic signed [npt2d_pkg::IN_W-1:0]      y_coord_i;
  logic                                   cfg_we_i;
  logic                                   cfg_idx_i;
  logic [npt2d_pkg::COORD_BITS-1:0]       cfg_wdata_i;
  logic                                   done_o;
  logic [2:0]                             status_o;
  logic [npt2d_pkg::COORD_BITS-1:0]       nearest_x_o;
  logic [npt2d_pkg::COORD_BITS-1:0]       nearest_y_o;
  logic [npt2d_pkg::DIST_W-1:0]           distance_squared_o;

  logic [npt2d_pkg::COORD_BITS-1:0]       stored_x [npt2d_pkg::MAX_POINTS];
  logic [npt2d_pkg::COORD_BITS-1:0]       stored_y [npt2d_pkg::MAX_POINTS];
  int                                     stored_count;
  int                                     limit_x;
  int                                     limit_y;
  nearest_result_t                        expected_results [$];
  int                                     error_count;
  int                                     idle_cycles;
  bit                                     random_gaps;

  nearest_point_table_2d_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .x_coord_i          (x_coord_i),
    .y_coord_i          (y_coord_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .nearest_x_o        (nearest_x_o),
    .nearest_y_o        (nearest_y_o),
    .distance_squared_o (distance_squared_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic nearest_result_t predict_table_result(
      input npt2d_pkg::action_e               act,
      input logic signed [npt2d_pkg::IN_W-1:0] x,
      input logic signed [npt2d_pkg::IN_W-1:0] y);
    nearest_result_t res;
    int              xi;
    int              yi;
    int              dx;
    int              dy;
    longint          d;
    longint          best;
    res  = '0;
    xi   = int'(x);
    yi   = int'(y);
    best = 0;
    if (act == npt2d_pkg::ACT_ADD) begin
      if (xi < 0 || yi < 0 || xi > limit_x || yi > limit_y || xi > COORD_MAX ||
          yi > COORD_MAX) begin
        res.status = npt2d_pkg::ST_RANGE;
      end else if (stored_count >= npt2d_pkg::MAX_POINTS) begin
        res.status = npt2d_pkg::ST_FULL;
      end else begin
        stored_x[stored_count] = (npt2d_pkg::COORD_BITS)'(xi);
        stored_y[stored_count] = (npt2d_pkg::COORD_BITS)'(yi);
        stored_count++;
        res.status = npt2d_pkg::ST_ADDED;
      end
    end else if (stored_count == 0) begin
      res.status = npt2d_pkg::ST_EMPTY;
    end else begin
      for (int i = 0; i < stored_count; i++) begin
        dx = int'(stored_x[i]) - xi;
        dy = int'(stored_y[i]) - yi;
        d  = longint'(dx) * dx + longint'(dy) * dy;
        // strict compare keeps the earliest stored point on ties
        if (i == 0 || d < best) begin
          best   = d;
          res.nx = stored_x[i];
          res.ny = stored_y[i];
        end
      end
      res.status  = npt2d_pkg::ST_FOUND;
      res.dist_sq = (npt2d_pkg::DIST_W)'(best);
    end
    return res;
  endfunction

  function automatic void add_expected(input nearest_result_t exp_item);
    expected_results.insert(expected_results.size(), exp_item);
  endfunction

  task automatic send_item(input npt2d_pkg::action_e act, input int x, input int y);
    int gap;
    gap = random_gaps ? $urandom_range(0, 19) : 0;
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start     = 1'b1;
    action_i  = act;
    x_coord_i = (npt2d_pkg::IN_W)'(x);
    y_coord_i = (npt2d_pkg::IN_W)'(y);
    do @(posedge clk_i); while (busy);
    add_expected(predict_table_result(act, (npt2d_pkg::IN_W)'(x), (npt2d_pkg::IN_W)'(y)));
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = (npt2d_pkg::COORD_BITS)'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == npt2d_pkg::REG_MAX_X) limit_x = value & COORD_MAX;
    else                             limit_y = value & COORD_MAX;
  endtask

  task automatic set_limits(input int lx, input int ly);
    wait_idle();
    write_reg(npt2d_pkg::REG_MAX_X, lx);
    write_reg(npt2d_pkg::REG_MAX_Y, ly);
  endtask

  task automatic send_random_add();
    int kind;
    int x;
    int y;
    kind = $urandom_range(0, 9);
    x    = $urandom_range(0, limit_x);
    y    = $urandom_range(0, limit_y);
    if (kind == 6 && stored_count > 0) begin
      kind = $urandom_range(0, stored_count - 1);
      x    = int'(stored_x[kind]);
      y    = int'(stored_y[kind]);
    end else if (kind == 7) begin
      if ($urandom_range(0, 1)) x = -int'($urandom_range(1, -IN_MIN));
      else                      y = -int'($urandom_range(1, -IN_MIN));
    end else if (kind == 8) begin
      if ($urandom_range(0, 1)) x = $urandom_range(limit_x + 1, IN_MAX);
      else                      y = $urandom_range(limit_y + 1, IN_MAX);
    end else if (kind == 9) begin
      x = int'($signed((npt2d_pkg::IN_W)'($urandom)));
      y = int'($signed((npt2d_pkg::IN_W)'($urandom)));
    end
    send_item(npt2d_pkg::ACT_ADD, x, y);
  endtask

  task automatic send_random_query();
    int kind;
    int idx;
    int x;
    int y;
    kind = $urandom_range(0, 9);
    x    = int'($signed((npt2d_pkg::IN_W)'($urandom)));
    y    = int'($signed((npt2d_pkg::IN_W)'($urandom)));
    if (kind < 3 && stored_count > 0) begin
      // close to a stored point, within 3 in each coordinate, sometimes exactly on it
      idx = $urandom_range(0, stored_count - 1);
      x   = int'(stored_x[idx]) + int'($urandom_range(0, 6)) - 3;
      y   = int'(stored_y[idx]) + int'($urandom_range(0, 6)) - 3;
    end else if (kind < 5) begin
      x = $urandom_range(0, COORD_MAX);
      y = $urandom_range(0, COORD_MAX);
    end
    send_item(npt2d_pkg::ACT_QUERY, x, y);
  endtask

  task automatic send_random_mix(input int count, input int add_pct);
    random_gaps = $urandom_range(0, 3) != 0;
    repeat (count) begin
      if ($urandom_range(0, 99) < add_pct) send_random_add();
      else                                 send_random_query();
    end
  endtask

  task automatic test_empty_table();
    send_item(npt2d_pkg::ACT_QUERY, IN_MIN, IN_MIN);
    send_item(npt2d_pkg::ACT_QUERY, IN_MAX, IN_MAX);
  endtask

  task automatic test_coord_edges();
    send_item(npt2d_pkg::ACT_ADD, 0, 0);
    send_item(npt2d_pkg::ACT_ADD, COORD_MAX, COORD_MAX);
    send_item(npt2d_pkg::ACT_ADD, -1, 0);
    send_item(npt2d_pkg::ACT_ADD, 0, -1);
    send_item(npt2d_pkg::ACT_ADD, COORD_MAX + 1, 0);
    send_item(npt2d_pkg::ACT_ADD, 0, COORD_MAX + 1);
    send_item(npt2d_pkg::ACT_ADD, IN_MAX, IN_MAX);
    send_item(npt2d_pkg::ACT_ADD, IN_MIN, IN_MIN);
    send_item(npt2d_pkg::ACT_QUERY, IN_MIN, IN_MIN);
    send_item(npt2d_pkg::ACT_QUERY, IN_MAX, IN_MAX);
  endtask

  task automatic test_zero_limits();
    set_limits(0, 0);
    send_item(npt2d_pkg::ACT_ADD, 0, 0);
    send_item(npt2d_pkg::ACT_ADD, 1, 0);
    send_item(npt2d_pkg::ACT_ADD, 0, 1);
  endtask

  task automatic test_tie_break();
    set_limits(COORD_MAX, COORD_MAX);
    send_item(npt2d_pkg::ACT_ADD, 300, 300);
    send_item(npt2d_pkg::ACT_ADD, 302, 300);
    send_item(npt2d_pkg::ACT_QUERY, 301, 300);
    send_item(npt2d_pkg::ACT_QUERY, 302, 300);
  endtask

  task automatic test_random_fill();
    int lx;
    int ly;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin lx = COORD_MAX; ly = COORD_MAX; end
        1:       begin lx = 0;         ly = COORD_MAX; end
        2:       begin lx = COORD_MAX; ly = 0;         end
        3:       begin lx = 512;       ly = 37;        end
        default: begin lx = $urandom_range(0, COORD_MAX); ly = $urandom_range(0, COORD_MAX); end
      endcase
      set_limits(lx, ly);
      send_random_mix(80, 60);
    end
    set_limits($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    random_gaps = 1'b1;
    while (stored_count < npt2d_pkg::MAX_POINTS) begin
      if ($urandom_range(0, 3) != 0) send_item(npt2d_pkg::ACT_ADD, $urandom_range(0, limit_x),
                                               $urandom_range(0, limit_y));
      else                           send_random_query();
    end
  endtask

  task automatic test_full_table();
    for (int p = 0; p < 4; p++) begin
      if (p == 0) set_limits(COORD_MAX, COORD_MAX);
      else        set_limits($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      send_random_mix(90, 50);
    end
  endtask

  always @(posedge clk_i) begin
    nearest_result_t exp_res;
    if (done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual status %0d", $time, status_o);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status_o);
          error_count++;
        end
        if (nearest_x_o !== exp_res.nx) begin
          $display("%0t: nearest_x expected %0d actual %0d", $time, exp_res.nx, nearest_x_o);
          error_count++;
        end
        if (nearest_y_o !== exp_res.ny) begin
          $display("%0t: nearest_y expected %0d actual %0d", $time, exp_res.ny, nearest_y_o);
          error_count++;
        end
        if (distance_squared_o !== exp_res.dist_sq) begin
          $display("%0t: distance_squared expected %0d actual %0d", $time, exp_res.dist_sq,
                   distance_squared_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else                            idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[nearest_point_table_2d_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    action_i     = npt2d_pkg::ACT_ADD;
    x_coord_i    = '0;
    y_coord_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = npt2d_pkg::REG_MAX_X;
    cfg_wdata_i  = '0;
    stored_count = 0;
    limit_x      = COORD_MAX;
    limit_y      = COORD_MAX;
    error_count  = 0;
    idle_cycles  = 0;
    random_gaps  = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_coord_edges();
    test_zero_limits();
    test_tie_break();
    test_random_fill();
    test_full_table();

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (error_count == 0) begin
      $display("[nearest_point_table_2d_core] OK");
    end else begin
      $display("[nearest_point_table_2d_core] ERROR");
    end
    $finish;
  end

endmodule
